FILE: sv/max_heap_priority_queue_assert.svh
// Assertion macros shared by the heap queue RTL.
// Both sample on clk and are off while rst_n is low.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

  // Sizing
  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 11;
  localparam int IDX_W    = $clog2(CAPACITY);
  // Slots 1.. are stored as sibling pairs: odd slot in one RAM, even in the other
  localparam int ROWS     = CAPACITY / 2;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [IDX_W+1:0]        wide_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ROW_W-1:0]        row_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_LAST,
    S_DN,
    S_DN_CMP,
    S_DONE
  } state_t;

  // Requests from the controller to the two slot RAMs
  typedef struct packed {
    row_t rd_row;
    logic wr_en;
    logic wr_odd;
    row_t wr_row;
    key_t wr_data;
  } mem_cmd_t;

  // Sibling-pair row holding slot i (i >= 1)
  function automatic row_t row_of(input idx_t i);
    idx_t m;
    m = i - idx_t'(1);
    return row_t'(m >> 1);
  endfunction

endpackage

FILE: sv/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// Binary max-heap priority queue, one item in flight: a new item is accepted only in idle.
// Insert: the key climbs one level per S_UP/S_UP_CMP pair while its parent is smaller.
// Remove: the last key is fetched (S_LAST), then sinks one level per S_DN/S_DN_CMP pair;
// full, empty and last-key cases go straight to S_DONE, which waits for out_ready.
// Reset (rst_n low, synchronous) empties the heap and clears the handshakes;
// the slot RAMs are not cleared, since only slots below the count are read.
module max_heap_priority_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic signed [31:0]  in_key_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_removed_value,
  output logic signed [31:0]  out_top_value,
  output logic [10:0]         out_entry_count,
  output logic [1:0]          out_status
);

  mhpq_pkg::mem_cmd_t mem_cmd;
  mhpq_pkg::key_t     rd_odd;
  mhpq_pkg::key_t     rd_even;
  logic               we_odd;
  logic               we_even;

  mhpq_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_key_value      (in_key_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_entry_count   (out_entry_count),
    .out_status        (out_status),
    .mem_cmd           (mem_cmd),
    .rd_odd            (rd_odd),
    .rd_even           (rd_even)
  );

  // Steer a slot write to the RAM holding its side of the pair
  assign we_odd  = mem_cmd.wr_en && mem_cmd.wr_odd;
  assign we_even = mem_cmd.wr_en && !mem_cmd.wr_odd;

  // Left children (odd slots)
  mhpq_ram #(
    .WIDTH (mhpq_pkg::KEY_W),
    .DEPTH (mhpq_pkg::ROWS)
  ) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (mem_cmd.wr_row),
    .wdata (mem_cmd.wr_data),
    .raddr (mem_cmd.rd_row),
    .rdata (rd_odd)
  );

  // Right children (even slots)
  mhpq_ram #(
    .WIDTH (mhpq_pkg::KEY_W),
    .DEPTH (mhpq_pkg::ROWS)
  ) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (mem_cmd.wr_row),
    .wdata (mem_cmd.wr_data),
    .raddr (mem_cmd.rd_row),
    .rdata (rd_even)
  );

endmodule

FILE: sv/mhpq_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mhpq_ctrl.sv
`timescale 1ns / 1ps

// Heap controller: root in a register, other slots in the pair RAMs.
// The moving key stays in key_r; each level writes the displaced key into the hole.
module mhpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  mhpq_pkg::key_t      in_key_value,
  output logic                out_valid,
  input  logic                out_ready,
  output mhpq_pkg::key_t      out_removed_value,
  output mhpq_pkg::key_t      out_top_value,
  output mhpq_pkg::cnt_t      out_entry_count,
  output logic [1:0]          out_status,
  output mhpq_pkg::mem_cmd_t  mem_cmd,
  input  mhpq_pkg::key_t      rd_odd,
  input  mhpq_pkg::key_t      rd_even
);

  `include "max_heap_priority_queue_assert.svh"

  mhpq_pkg::state_t  state_r, state_nxt;
  mhpq_pkg::cnt_t    cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  mhpq_pkg::key_t    key_r, key_nxt;
  mhpq_pkg::idx_t    pos_r, pos_nxt;
  mhpq_pkg::idx_t    par_r, par_nxt;
  logic              odd_r, odd_nxt;
  logic              right_ok_r, right_ok_nxt;
  mhpq_pkg::key_t    top_r, top_nxt;
  mhpq_pkg::key_t    removed_r, removed_nxt;
  mhpq_pkg::status_t status_r, status_nxt;
  mhpq_pkg::key_t    out_removed_r, out_removed_nxt;
  mhpq_pkg::key_t    out_top_r, out_top_nxt;
  mhpq_pkg::cnt_t    out_cnt_r, out_cnt_nxt;
  mhpq_pkg::status_t out_status_r, out_status_nxt;

  // Scratch values of the next-state logic
  mhpq_pkg::idx_t    parent;
  mhpq_pkg::idx_t    last_idx;
  mhpq_pkg::wide_t   left_w;
  mhpq_pkg::wide_t   right_w;
  mhpq_pkg::wide_t   cnt_w;
  mhpq_pkg::key_t    rd_sel;
  mhpq_pkg::key_t    pval;
  mhpq_pkg::key_t    cval;
  logic              take_right;
  logic              wr_go;
  mhpq_pkg::idx_t    wr_idx;
  mhpq_pkg::key_t    wr_val;
  logic              out_load;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhpq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    pos_r         <= pos_nxt;
    par_r         <= par_nxt;
    odd_r         <= odd_nxt;
    right_ok_r    <= right_ok_nxt;
    top_r         <= top_nxt;
    removed_r     <= removed_nxt;
    status_r      <= status_nxt;
    out_removed_r <= out_removed_nxt;
    out_top_r     <= out_top_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Next state, memory requests and result
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    key_nxt         = key_r;
    pos_nxt         = pos_r;
    par_nxt         = par_r;
    odd_nxt         = odd_r;
    right_ok_nxt    = right_ok_r;
    top_nxt         = top_r;
    removed_nxt     = removed_r;
    status_nxt      = status_r;
    out_removed_nxt = out_removed_r;
    out_top_nxt     = out_top_r;
    out_cnt_nxt     = out_cnt_r;
    out_status_nxt  = out_status_r;
    mem_cmd         = '0;
    wr_go           = 1'b0;
    wr_idx          = pos_r;
    wr_val          = key_r;
    out_load        = 1'b0;

    parent     = (pos_r - mhpq_pkg::idx_t'(1)) >> 1;
    last_idx   = mhpq_pkg::idx_t'(cnt_r - mhpq_pkg::cnt_t'(1));
    left_w     = mhpq_pkg::wide_t'({pos_r, 1'b1});
    right_w    = left_w + mhpq_pkg::wide_t'(1);
    cnt_w      = mhpq_pkg::wide_t'(cnt_r);
    rd_sel     = odd_r ? rd_odd : rd_even;
    pval       = (par_r == '0) ? top_r : rd_sel;
    take_right = right_ok_r && (rd_even > rd_odd);
    cval       = take_right ? rd_even : rd_odd;

    // Result leaves when taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (in_valid) begin
          removed_nxt = '0;
          status_nxt  = mhpq_pkg::ST_OK;
          if (in_req_type == mhpq_pkg::REQ_INSERT) begin
            if (cnt_r == mhpq_pkg::CAP_CNT) begin
              status_nxt = mhpq_pkg::ST_FULL;
              state_nxt  = mhpq_pkg::S_DONE;
            end else begin
              key_nxt   = in_key_value;
              pos_nxt   = mhpq_pkg::idx_t'(cnt_r);
              cnt_nxt   = cnt_r + mhpq_pkg::cnt_t'(1);
              state_nxt = mhpq_pkg::S_UP;
            end
          end else if (cnt_r == '0) begin
            status_nxt = mhpq_pkg::ST_EMPTY;
            state_nxt  = mhpq_pkg::S_DONE;
          end else begin
            removed_nxt = top_r;
            cnt_nxt     = cnt_r - mhpq_pkg::cnt_t'(1);
            if (cnt_r == mhpq_pkg::cnt_t'(1)) begin
              state_nxt = mhpq_pkg::S_DONE;
            end else begin
              // fetch the last key, it becomes the moving key
              mem_cmd.rd_row = mhpq_pkg::row_of(last_idx);
              odd_nxt        = last_idx[0];
              state_nxt      = mhpq_pkg::S_LAST;
            end
          end
        end
      end

      mhpq_pkg::S_UP: begin
        if (pos_r == '0) begin
          wr_go     = 1'b1;
          state_nxt = mhpq_pkg::S_DONE;
        end else begin
          mem_cmd.rd_row = mhpq_pkg::row_of(parent);
          odd_nxt        = parent[0];
          par_nxt        = parent;
          state_nxt      = mhpq_pkg::S_UP_CMP;
        end
      end

      mhpq_pkg::S_UP_CMP: begin
        wr_go = 1'b1;
        if (pval < key_r) begin
          // parent drops into the hole, hole moves up
          wr_val    = pval;
          pos_nxt   = par_r;
          state_nxt = mhpq_pkg::S_UP;
        end else begin
          state_nxt = mhpq_pkg::S_DONE;
        end
      end

      mhpq_pkg::S_LAST: begin
        key_nxt   = rd_sel;
        pos_nxt   = '0;
        state_nxt = mhpq_pkg::S_DN;
      end

      mhpq_pkg::S_DN: begin
        if (left_w >= cnt_w) begin
          wr_go     = 1'b1;
          state_nxt = mhpq_pkg::S_DONE;
        end else begin
          // children of slot p share row p
          mem_cmd.rd_row = mhpq_pkg::row_t'(pos_r);
          right_ok_nxt   = right_w < cnt_w;
          state_nxt      = mhpq_pkg::S_DN_CMP;
        end
      end

      mhpq_pkg::S_DN_CMP: begin
        wr_go = 1'b1;
        if (cval > key_r) begin
          // larger child rises into the hole, left wins ties
          wr_val    = cval;
          pos_nxt   = mhpq_pkg::idx_t'(left_w + mhpq_pkg::wide_t'(take_right));
          state_nxt = mhpq_pkg::S_DN;
        end else begin
          state_nxt = mhpq_pkg::S_DONE;
        end
      end

      mhpq_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load        = 1'b1;
          out_valid_nxt   = 1'b1;
          out_removed_nxt = removed_r;
          out_top_nxt     = (cnt_r != '0) ? top_r : '0;
          out_cnt_nxt     = cnt_r;
          out_status_nxt  = status_r;
          state_nxt       = mhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mhpq_pkg::S_IDLE;
      end
    endcase

    // Slot write: root goes to its register, the rest to the pair RAMs
    if (wr_go) begin
      if (wr_idx == '0) begin
        top_nxt = wr_val;
      end else begin
        mem_cmd.wr_en   = 1'b1;
        mem_cmd.wr_odd  = wr_idx[0];
        mem_cmd.wr_row  = mhpq_pkg::row_of(wr_idx);
        mem_cmd.wr_data = wr_val;
      end
    end
  end

  assign in_ready          = (state_r == mhpq_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_top_value     = out_top_r;
  assign out_entry_count   = out_cnt_r;
  assign out_status        = out_status_r;

  `MHPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, state_r != mhpq_pkg::S_IDLE,
    "accepted item did not start work")
  `MHPQ_ASSERT_NOW(a_full_count, out_load && status_r == mhpq_pkg::ST_FULL,
    cnt_r == mhpq_pkg::CAP_CNT, "full status without a full heap")
  `MHPQ_ASSERT_NOW(a_empty_count, out_load && status_r == mhpq_pkg::ST_EMPTY,
    cnt_r == '0 && removed_r == '0, "empty status with keys held")
  `MHPQ_ASSERT_NOW(a_write_state, mem_cmd.wr_en,
    state_r == mhpq_pkg::S_UP_CMP || state_r == mhpq_pkg::S_DN_CMP ||
    state_r == mhpq_pkg::S_DN, "slot RAM written outside a sift step")

endmodule

FILE: tb/max_heap_priority_queue_tb.sv
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;

  localparam int             WATCHDOG_LIMIT = 1000;
  localparam int             SETTLE_CYCLES  = 30;
  localparam int             DIR_ROWS       = 22;
  localparam int             RAND_ITEMS     = 400;
  localparam int             BLOCK_ITEMS    = 50;
  localparam int             N_BLOCKS       = RAND_ITEMS / BLOCK_ITEMS;
  localparam mhpq_pkg::key_t KEY_MAX        = 32'sh7fffffff;
  localparam mhpq_pkg::key_t KEY_MIN        = 32'sh80000000;

  // One result item of the queue
  typedef struct packed {
    mhpq_pkg::key_t    removed;
    mhpq_pkg::key_t    top;
    mhpq_pkg::cnt_t    count;
    mhpq_pkg::status_t status;
  } heap_result_t;

  // Directed row: fixed expectation used only when typed is set
  typedef struct packed {
    logic           req;
    mhpq_pkg::key_t key;
    logic           typed;
    heap_result_t   exp;
  } dir_row_t;

  localparam heap_result_t NO_CHECK = '{32'sd0, 32'sd0, 11'd0, mhpq_pkg::ST_OK};

  logic           clk;
  logic           rst_n        = 1'b0;
  logic           in_valid     = 1'b0;
  logic           in_req_type  = mhpq_pkg::REQ_INSERT;
  mhpq_pkg::key_t in_key_value = '0;
  logic           in_ready;
  logic           out_valid;
  logic           out_ready    = 1'b0;
  mhpq_pkg::key_t out_removed_value;
  mhpq_pkg::key_t out_top_value;
  mhpq_pkg::cnt_t out_entry_count;
  logic [1:0]     out_status;

  max_heap_priority_queue i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_key_value      (in_key_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_entry_count   (out_entry_count),
    .out_status        (out_status)
  );

  // Shadow heap and pending results
  mhpq_pkg::key_t heap_keys [mhpq_pkg::CAPACITY];
  int             key_count;
  heap_result_t   pending_results [$];

  bit send_idle;
  bit recv_idle;
  int errors;
  int n_items, n_inserts, n_removes, n_full_drops, n_empty_removes, n_checked;
  int peak_count;

  // Directed stimulus: empty remove, extremes, ties, last-key remove
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,  1'b1, '{32'sd0,  32'sd0,  11'd0, mhpq_pkg::ST_EMPTY}},
    '{mhpq_pkg::REQ_INSERT, KEY_MAX, 1'b1, '{32'sd0,  KEY_MAX, 11'd1, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::REQ_INSERT, KEY_MIN, 1'b1, '{32'sd0,  KEY_MAX, 11'd2, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::REQ_INSERT, 32'sd0,  1'b1, '{32'sd0,  KEY_MAX, 11'd3, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::REQ_INSERT, -32'sd1, 1'b1, '{32'sd0,  KEY_MAX, 11'd4, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,  1'b1, '{KEY_MAX, 32'sd0,  11'd3, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::REQ_INSERT, 32'sd5,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_INSERT, 32'sd5,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_INSERT, 32'sd5,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_INSERT, 32'sd3,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_INSERT, 32'sh55555555, 1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_INSERT, 32'shAAAAAAAA, 1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,        1'b0, NO_CHECK},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,  1'b1, '{KEY_MIN, 32'sd0,  11'd0, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::REQ_REMOVE, 32'sd0,  1'b1, '{32'sd0,  32'sd0,  11'd0, mhpq_pkg::ST_EMPTY}}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow heap and return the result it causes
  function automatic heap_result_t heap_apply(input logic req, input mhpq_pkg::key_t key);
    heap_result_t   r;
    int             pos, up, lc, rc, big;
    mhpq_pkg::key_t tmp;
    r = '0;
    r.status = mhpq_pkg::ST_OK;
    if (req == mhpq_pkg::REQ_INSERT) begin
      if (key_count >= mhpq_pkg::CAPACITY) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        // place last, climb while parent strictly smaller
        pos = key_count;
        heap_keys[pos] = key;
        key_count++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[up] < heap_keys[pos])) break;
          tmp = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = up;
        end
      end
    end else begin
      if (key_count == 0) begin
        r.status = mhpq_pkg::ST_EMPTY;
      end else begin
        // take root, move last to root, sink toward larger child (left on tie)
        r.removed = heap_keys[0];
        key_count--;
        heap_keys[0] = heap_keys[key_count];
        pos = 0;
        while (1) begin
          lc  = 2 * pos + 1;
          rc  = lc + 1;
          big = pos;
          if (lc >= key_count) break;
          if (heap_keys[lc] > heap_keys[big]) big = lc;
          if (rc < key_count && heap_keys[rc] > heap_keys[big]) big = rc;
          if (big == pos) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[big];
          heap_keys[big] = tmp;
          pos = big;
        end
      end
    end
    r.top   = (key_count != 0) ? heap_keys[0] : mhpq_pkg::key_t'(0);
    r.count = mhpq_pkg::cnt_t'(key_count);
    return r;
  endfunction

  // Keys: small range for ties, extremes, or anything
  function automatic mhpq_pkg::key_t pick_key();
    case ($urandom_range(0, 7))
      0, 1: return mhpq_pkg::key_t'($urandom_range(0, 15)) - 32'sd8;
      2: return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
      default: return mhpq_pkg::key_t'($urandom);
    endcase
  endfunction

  // Drive one item, wait for acceptance, record its expectation
  task automatic send_item(input logic req, input mhpq_pkg::key_t key, input logic typed,
                           input heap_result_t fixed_exp);
    heap_result_t pred;
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_key_value <= key;
    do @(posedge clk); while (!in_ready);
    pred = heap_apply(req, key);
    pending_results.push_back(typed ? fixed_exp : pred);
    n_items++;
    if (req == mhpq_pkg::REQ_INSERT) n_inserts++;
    else n_removes++;
    if (pred.status == mhpq_pkg::ST_FULL) n_full_drops++;
    if (pred.status == mhpq_pkg::ST_EMPTY) n_empty_removes++;
    if (key_count > peak_count) peak_count = key_count;
    // random sender gap
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic req, input mhpq_pkg::key_t key);
    send_item(req, key, 1'b0, NO_CHECK);
  endtask

  // Hold the sender until every pending result has come back
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver back-pressure in bursts
  initial begin : ready_drive
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    heap_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: removed %h top %h count %0d status %0d",
                 $time, out_removed_value, out_top_value, out_entry_count, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("removed_value", want.removed, out_removed_value);
        check_field("top_value", want.top, out_top_value);
        check_field("entry_count", 32'(want.count), 32'(out_entry_count));
        check_field("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  // Watchdog: cycles with no item moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no item moved for %0d cycles, %0d results pending",
             $time, WATCHDOG_LIMIT, pending_results.size());
    $display("tb: failure");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    int ins_pct;
    key_count  = 0;
    errors     = 0;
    n_items    = 0;
    n_inserts  = 0;
    n_removes  = 0;
    n_full_drops    = 0;
    n_empty_removes = 0;
    n_checked  = 0;
    peak_count = 0;
    send_idle  = 1'b1;
    recv_idle  = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_tbl[i])
      send_item(dir_tbl[i].req, dir_tbl[i].key, dir_tbl[i].typed, dir_tbl[i].exp);
    in_valid <= 1'b0;
    wait_drained();

    // fill to capacity, push on full, churn at the top
    while (key_count < mhpq_pkg::CAPACITY) send_op(mhpq_pkg::REQ_INSERT, pick_key());
    send_op(mhpq_pkg::REQ_INSERT, KEY_MAX);
    send_op(mhpq_pkg::REQ_INSERT, KEY_MIN);
    send_op(mhpq_pkg::REQ_INSERT, pick_key());
    repeat (20) begin
      send_op(mhpq_pkg::REQ_REMOVE, 32'sd0);
      send_op(mhpq_pkg::REQ_INSERT, pick_key());
      send_op(mhpq_pkg::REQ_INSERT, pick_key());
    end
    in_valid <= 1'b0;
    wait_drained();

    // random mix in blocks of varying insert bias; every fourth block and the last three run without idling
    for (int blk = 0; blk < N_BLOCKS; blk++) begin
      case ($urandom_range(0, 3))
        0: ins_pct = 30;
        1: ins_pct = 50;
        2: ins_pct = 70;
        default: ins_pct = 90;
      endcase
      send_idle = (blk < N_BLOCKS - 3) && (blk % 4 != 3);
      recv_idle = send_idle;
      repeat (BLOCK_ITEMS) begin
        if ($urandom_range(1, 100) <= ins_pct) send_op(mhpq_pkg::REQ_INSERT, pick_key());
        else send_op(mhpq_pkg::REQ_REMOVE, mhpq_pkg::key_t'($urandom));
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d items sent (%0d inserts, %0d removes), %0d results checked",
             n_items, n_inserts, n_removes, n_checked);
    $display("tb: %0d inserts dropped on a full heap, %0d removes on empty, peak count %0d",
             n_full_drops, n_empty_removes, peak_count);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
